### sv/melody_tone_sequencer_top_macros.svh
// Assertion macros for the melody tone sequencer.
// Included by melody_tone_sequencer_top; empty when SYNTHESIS is defined.
`ifndef MELODY_TONE_SEQUENCER_TOP_MACROS_SVH
`define MELODY_TONE_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MTS_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("melody tone sequencer: invariant violated");
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("melody tone sequencer: sequence violated");
`else
`define MTS_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/mts_pkg.sv
// Shared types, codes and constants of the melody tone sequencer.
// No dependencies; used by mts_cfg and melody_tone_sequencer_top.
package mts_pkg;

  localparam int NOTE_DEPTH_DEF    = 64;
  localparam int SONG_PICK_PRESSES = 2;
  localparam int NOTE_W            = 24;
  localparam int START_SPAN        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 8;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_SELECT = 3'd1;
  localparam logic [2:0] FUNC_KNOCK  = 3'd2;
  localparam logic [2:0] FUNC_PAUSE  = 3'd3;
  localparam logic [2:0] FUNC_WRITE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 3'd5;

  localparam logic [5:0] RST_FIRST_START   = 6'd0;
  localparam logic [6:0] RST_FIRST_LENGTH  = 7'd30;
  localparam logic [5:0] RST_SECOND_START  = 6'd30;
  localparam logic [6:0] RST_SECOND_LENGTH = 7'd26;
  localparam logic [7:0] RST_WINDOW_TICKS  = 8'd8;
  localparam logic [7:0] RST_SETTLE_TICKS  = 8'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  note_addr;
    logic [15:0] note_period;
    logic [7:0]  note_ticks;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tone_period;
    logic        relay_on;
    logic        select_enable;
    logic        listen_enable;
    logic        is_playing;
    logic        song_active;
  } out_item_t;

  typedef struct packed {
    logic [5:0] first_song_start;
    logic [6:0] first_song_length;
    logic [5:0] second_song_start;
    logic [6:0] second_song_length;
    logic [7:0] window_ticks;
    logic [7:0] settle_ticks;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_ADV,
    S_RESUME,
    S_PUSH
  } state_t;

endpackage

### sv/mts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the note store.
module mts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/mts_cfg.sv
// Configuration register file of the melody tone sequencer.
// Depends on mts_pkg for the register struct, indexes and reset values.
module mts_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_data,
  output mts_pkg::cfg_regs_t             regs
);
  import mts_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_START:   regs_nxt.first_song_start   = cfg_data[5:0];
        CFG_FIRST_LENGTH:  regs_nxt.first_song_length  = cfg_data[6:0];
        CFG_SECOND_START:  regs_nxt.second_song_start  = cfg_data[5:0];
        CFG_SECOND_LENGTH: regs_nxt.second_song_length = cfg_data[6:0];
        CFG_WINDOW_TICKS:  regs_nxt.window_ticks       = cfg_data;
        CFG_SETTLE_TICKS:  regs_nxt.settle_ticks       = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.first_song_start   <= RST_FIRST_START;
      regs_r.first_song_length  <= RST_FIRST_LENGTH;
      regs_r.second_song_start  <= RST_SECOND_START;
      regs_r.second_song_length <= RST_SECOND_LENGTH;
      regs_r.window_ticks       <= RST_WINDOW_TICKS;
      regs_r.settle_ticks       <= RST_SETTLE_TICKS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

### sv/melody_tone_sequencer_top.sv
// From item acceptance to a valid result the sequencer steps through an execute state, one
// state per note store read (song start, note advance, resume) and an output load state
// that waits for a free output slot. Items are taken only when idle, as the sequencer steps
// through the single read port of the note store; a new item is taken while the last result waits.
// Reset (rst_n low at a clock edge) clears all control state and configuration; the note
// store keeps its contents and is undefined until written.
`include "melody_tone_sequencer_top_macros.svh"
module melody_tone_sequencer_top #(
  parameter int NOTE_DEPTH = mts_pkg::NOTE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mts_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mts_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mts_pkg::*;

  localparam int AW = $clog2(NOTE_DEPTH);

  cfg_regs_t cfg_regs;

  state_t state_r, state_nxt;
  in_item_t item_r;

  logic          playing_r, playing_nxt;
  logic          active_r, active_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [6:0]    notes_r, notes_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [15:0]   tone_r, tone_nxt;
  logic          relay_r, relay_nxt;
  logic          select_r, select_nxt;
  logic          listen_r, listen_nxt;
  logic          counting_r, counting_nxt;
  logic          pending_r, pending_nxt;
  logic [7:0]    press_r, press_nxt;
  logic [7:0]    window_r, window_nxt;
  logic [7:0]    settle_r, settle_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [NOTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [NOTE_W-1:0] ram_rdata;
  logic [15:0]       rd_period;
  logic [7:0]        rd_ticks;

  logic [AW-1:0] start_wrap [START_SPAN];
  logic [AW-1:0] ptr_inc;
  logic          pick_second;
  logic [5:0]    start_idx;
  logic [AW-1:0] start_ptr;
  logic [6:0]    start_len;
  logic          slot_free;
  logic          go_start, go_adv, go_resume;

  mts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg_regs)
  );

  // Accesses are sequenced per item, so a read never overlaps a write to the same entry.
  mts_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar gi = 0; gi < START_SPAN; gi++) begin : g_wrap
    assign start_wrap[gi] = AW'(gi % NOTE_DEPTH);
  end

  assign rd_period   = ram_rdata[NOTE_W-1 -: 16];
  assign rd_ticks    = ram_rdata[7:0];
  assign ptr_inc     = (ptr_r == AW'(NOTE_DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  assign pick_second = press_r >= 8'(SONG_PICK_PRESSES);
  assign start_idx   = pick_second ? cfg_regs.second_song_start : cfg_regs.first_song_start;
  assign start_len   = pick_second ? cfg_regs.second_song_length : cfg_regs.first_song_length;
  assign start_ptr   = start_wrap[start_idx];
  assign slot_free   = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go_start) begin
          state_nxt = S_START;
        end else if (go_adv) begin
          state_nxt = S_ADV;
        end else if (go_resume) begin
          state_nxt = S_RESUME;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_START: begin
        state_nxt = go_adv ? S_ADV : S_PUSH;
      end
      S_ADV:    state_nxt = S_PUSH;
      S_RESUME: state_nxt = S_PUSH;
      S_PUSH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    playing_nxt   = playing_r;
    active_nxt    = active_r;
    ptr_nxt       = ptr_r;
    notes_nxt     = notes_r;
    hold_nxt      = hold_r;
    tone_nxt      = tone_r;
    relay_nxt     = relay_r;
    select_nxt    = select_r;
    listen_nxt    = listen_r;
    counting_nxt  = counting_r;
    pending_nxt   = pending_r;
    press_nxt     = press_r;
    window_nxt    = window_r;
    settle_nxt    = settle_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(item_r.note_addr);
    ram_wdata     = {item_r.note_period, item_r.note_ticks};
    ram_re        = 1'b0;
    ram_raddr     = ptr_inc;
    go_start      = 1'b0;
    go_adv        = 1'b0;
    go_resume     = 1'b0;

    case (state_r)
      S_EXEC: begin
        case (item_r.func)
          FUNC_TICK: begin
            if (counting_r) begin
              if (window_r >= cfg_regs.window_ticks) begin
                window_nxt   = '0;
                counting_nxt = 1'b0;
                go_start     = 1'b1;
                ptr_nxt      = start_ptr;
                notes_nxt    = start_len;
                ram_re       = 1'b1;
                ram_raddr    = start_ptr;
              end else begin
                window_nxt = window_r + 8'd1;
                if (pending_r) begin
                  if (press_r != 8'hFF) begin
                    press_nxt = press_r + 8'd1;
                  end
                  pending_nxt = 1'b0;
                end
              end
            end
            if (!go_start) begin
              if (playing_r) begin
                if (hold_r == '0) begin
                  if (notes_r <= 7'd1) begin
                    notes_nxt   = '0;
                    playing_nxt = 1'b0;
                    active_nxt  = 1'b0;
                    tone_nxt    = '0;
                    relay_nxt   = 1'b0;
                    select_nxt  = 1'b1;
                    if (settle_r >= cfg_regs.settle_ticks) begin
                      listen_nxt = 1'b1;
                    end else begin
                      settle_nxt = settle_r + 8'd1;
                    end
                  end else begin
                    notes_nxt  = notes_r - 7'd1;
                    ptr_nxt    = ptr_inc;
                    ram_re     = 1'b1;
                    go_adv     = 1'b1;
                    settle_nxt = '0;
                  end
                end else begin
                  hold_nxt   = hold_r - 8'd1;
                  settle_nxt = '0;
                end
              end else if (settle_r >= cfg_regs.settle_ticks) begin
                listen_nxt = 1'b1;
              end else begin
                settle_nxt = settle_r + 8'd1;
              end
            end
          end
          FUNC_SELECT, FUNC_KNOCK: begin
            if ((item_r.func == FUNC_SELECT) ? select_r : listen_r) begin
              if (!counting_r) begin
                press_nxt    = '0;
                counting_nxt = 1'b1;
              end
              pending_nxt = 1'b1;
            end
          end
          FUNC_PAUSE: begin
            if (active_r) begin
              if (playing_r) begin
                tone_nxt    = '0;
                relay_nxt   = 1'b0;
                select_nxt  = 1'b1;
                playing_nxt = 1'b0;
              end else begin
                go_resume = 1'b1;
                ram_re    = 1'b1;
                ram_raddr = ptr_r;
              end
            end
          end
          FUNC_WRITE: begin
            if (32'(item_r.note_addr) < NOTE_DEPTH) begin
              ram_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_START: begin
        relay_nxt   = 1'b1;
        listen_nxt  = 1'b0;
        select_nxt  = 1'b0;
        tone_nxt    = rd_period;
        playing_nxt = 1'b1;
        active_nxt  = 1'b1;
        hold_nxt    = rd_ticks;
        if (rd_ticks == '0) begin
          if (notes_r <= 7'd1) begin
            notes_nxt   = '0;
            playing_nxt = 1'b0;
            active_nxt  = 1'b0;
            tone_nxt    = '0;
            relay_nxt   = 1'b0;
            select_nxt  = 1'b1;
            if (settle_r >= cfg_regs.settle_ticks) begin
              listen_nxt = 1'b1;
            end else begin
              settle_nxt = settle_r + 8'd1;
            end
          end else begin
            notes_nxt  = notes_r - 7'd1;
            ptr_nxt    = ptr_inc;
            ram_re     = 1'b1;
            go_adv     = 1'b1;
            settle_nxt = '0;
          end
        end else begin
          hold_nxt   = rd_ticks - 8'd1;
          settle_nxt = '0;
        end
      end
      S_ADV: begin
        hold_nxt = rd_ticks;
        tone_nxt = rd_period;
      end
      S_RESUME: begin
        relay_nxt   = 1'b1;
        listen_nxt  = 1'b0;
        select_nxt  = 1'b0;
        tone_nxt    = rd_period;
        playing_nxt = 1'b1;
      end
      S_PUSH: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.tone_period   = tone_r;
          out_data_nxt.relay_on      = relay_r;
          out_data_nxt.select_enable = select_r;
          out_data_nxt.listen_enable = listen_r;
          out_data_nxt.is_playing    = playing_r;
          out_data_nxt.song_active   = active_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      playing_r   <= 1'b0;
      active_r    <= 1'b0;
      ptr_r       <= '0;
      notes_r     <= '0;
      hold_r      <= '0;
      tone_r      <= '0;
      relay_r     <= 1'b0;
      select_r    <= 1'b1;
      listen_r    <= 1'b1;
      counting_r  <= 1'b0;
      pending_r   <= 1'b0;
      press_r     <= '0;
      window_r    <= '0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      active_r    <= active_nxt;
      ptr_r       <= ptr_nxt;
      notes_r     <= notes_nxt;
      hold_r      <= hold_nxt;
      tone_r      <= tone_nxt;
      relay_r     <= relay_nxt;
      select_r    <= select_nxt;
      listen_r    <= listen_nxt;
      counting_r  <= counting_nxt;
      pending_r   <= pending_nxt;
      press_r     <= press_nxt;
      window_r    <= window_nxt;
      settle_r    <= settle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  `MTS_ASSERT_ALWAYS(a_play_needs_active, clk, rst_n, !playing_r || active_r)
  `MTS_ASSERT_ALWAYS(a_play_drives_relay, clk, rst_n, !playing_r || (relay_r && !select_r && !listen_r))
  `MTS_ASSERT_NEXT(a_accept_executes, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `MTS_ASSERT_NEXT(a_push_loads_out, clk, rst_n, state_r == S_PUSH && slot_free, out_valid_r && state_r == S_IDLE)

endmodule
